// ===== hdl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted record table
// Opcodes, status codes, record and command structures, sizing constants.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int Depth   = 64;
  localparam int IdxW    = $clog2(Depth);
  localparam int CntMinW = $clog2(Depth + 1);
  localparam int EntryW  = 7;
  localparam int CntW    = (CntMinW > EntryW) ? CntMinW : EntryW;
  localparam int RankW   = 6;
  localparam int WordW   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_RANK  = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [WordW-1:0] key;
    logic signed [WordW-1:0] amount;
    logic        [WordW-1:0] price;
  } rec_t;

  typedef struct packed {
    op_e                     op;
    logic signed [WordW-1:0] key;
    logic signed [WordW-1:0] amount;
    logic        [WordW-1:0] price;
    logic        [RankW-1:0] rank;
  } cmd_t;

  // Per-cell write enables for the apply cycle.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    logic upd_en;
  } ctl_t;

endpackage

// ===== hdl/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell: one slot of the ordered shift array
// Compares its record with the command key, then keeps, loads, shifts, or updates its amount.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [skt_pkg::IdxW-1:0] idx_i,
  input  logic [skt_pkg::CntW-1:0] count_i,
  input  skt_pkg::cmd_t            cmd_i,
  input  skt_pkg::ctl_t            ctl_i,
  input  logic                     left_lt_i,
  input  skt_pkg::rec_t            left_rec_i,
  input  skt_pkg::rec_t            right_rec_i,
  output skt_pkg::rec_t            rec_o,
  output logic                     lt_o,
  output logic                     eq_o,
  output skt_pkg::rec_t            rd_o
);
  import skt_pkg::*;

  rec_t rec_q, rec_d;
  rec_t rd_q;
  logic lt_q, eq_q;
  logic occ;
  logic sel;

  assign occ = CntW'(idx_i) < count_i;
  assign sel = occ && (CntW'(idx_i) == CntW'(cmd_i.rank));

  // Flags compare against the held command key; always loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= occ && (rec_q.key < cmd_i.key);
      eq_q <= occ && (rec_q.key == cmd_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= sel ? rec_q : '0;
    rec_q <= rec_d;
  end

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins_en && !lt_q) begin
      if (left_lt_i) begin
        rec_d.key    = cmd_i.key;
        rec_d.amount = cmd_i.amount;
        rec_d.price  = cmd_i.price;
      end else begin
        rec_d = left_rec_i;
      end
    end else if (ctl_i.rem_en && !lt_q) begin
      rec_d = right_rec_i;
    end else if (ctl_i.upd_en && eq_q) begin
      rec_d.amount = cmd_i.amount;
    end
  end

  assign rec_o = rec_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;
  assign rd_o  = rd_q;

endmodule

// ===== hdl/sorted_keyed_record_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_core: ordered record table on a shift array
// A command taken into cmd_q passes the compare phase, then the apply phase, then raises the result strobe.
// Busy is high for the compare phase only, so a new command can be taken in the apply phase of the last.
// Cells register lt/eq and read data in the compare phase and update their records in the apply phase.
// Reset clears the count, phase and strobe; record storage is not cleared.
// The receiver cannot stall: each result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic signed [31:0]           key_i,
  input  logic signed [31:0]           amount_i,
  input  logic [31:0]                  price_word_i,
  input  logic [skt_pkg::RankW-1:0]    rank_i,
  output logic                         valid_o,
  output logic [2:0]                   status_o,
  output logic [skt_pkg::EntryW-1:0]   entry_count_o,
  output logic signed [31:0]           out_key_o,
  output logic signed [31:0]           out_amount_o,
  output logic [31:0]                  out_price_o
);
  import skt_pkg::*;

  // Command beat, held through compare and apply phases.
  cmd_t cmd_q;
  logic cmp_q;    // compare phase: cells register lt/eq and read data
  logic apl_q;    // apply phase: cells update, result is registered
  logic [CntW-1:0] count_q, count_d;

  rec_t rec   [Depth];
  rec_t rd    [Depth];
  logic lt    [Depth];
  logic eq    [Depth];
  logic lft_lt[Depth];
  rec_t lft   [Depth];
  rec_t rgt   [Depth];

  ctl_t ctl;
  logic found;
  logic full;
  logic bad_rank;
  rec_t rd_any;
  status_e status_d;
  rec_t    out_d;

  rec_t    out_q;
  status_e status_q;
  logic    valid_q;

  logic accept;

  assign busy   = cmp_q;
  assign accept = start && !busy;

  // Take a new command; the apply phase of the previous one may share this edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op     <= op_e'(opcode_i);
      cmd_q.key    <= key_i;
      cmd_q.amount <= amount_i;
      cmd_q.price  <= price_word_i;
      cmd_q.rank   <= rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q   <= 1'b0;
      apl_q   <= 1'b0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      cmp_q   <= accept;
      apl_q   <= cmp_q;
      count_q <= count_d;
      valid_q <= apl_q;
    end
  end

  // Hold result payload until the next beat overwrites it.
  always_ff @(posedge clk_i) begin
    if (apl_q) begin
      status_q <= status_d;
      out_q    <= out_d;
    end
  end

  // Reduce the cell flags and gated read data.
  always_comb begin
    found  = 1'b0;
    rd_any = '0;
    for (int i = 0; i < Depth; i++) begin
      found  = found | eq[i];
      rd_any = rd_any | rd[i];
    end
  end

  assign full     = count_q == CntW'(Depth);
  assign bad_rank = CntW'(cmd_q.rank) >= count_q;

  // Decide status and the per-cell enables for the apply phase.
  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    status_d = ST_OK;
    out_d    = '0;
    unique case (cmd_q.op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (found) begin
          status_d = ST_DUPLICATE;
        end else begin
          ctl.ins_en = apl_q;
          if (apl_q) count_d = count_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          ctl.rem_en = apl_q;
          if (apl_q) count_d = count_q - 1'b1;
        end
      end
      OP_UPDATE: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          ctl.upd_en = apl_q;
        end
      end
      OP_READ: begin
        if (bad_rank) begin
          status_d = ST_BAD_RANK;
        end else begin
          out_d = rd_any;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Wire each cell to its neighbors; the row ends see their own record, and cell 0 a tied-high left flag.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lft_lt[g] = 1'b1;
      assign lft[g]    = rec[g];
    end else begin : g_mid
      assign lft_lt[g] = lt[g-1];
      assign lft[g]    = rec[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign rgt[g] = rec[g];
    end else begin : g_inner
      assign rgt[g] = rec[g+1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IdxW'(g)),
      .count_i    (count_q),
      .cmd_i      (cmd_q),
      .ctl_i      (ctl),
      .left_lt_i  (lft_lt[g]),
      .left_rec_i (lft[g]),
      .right_rec_i(rgt[g]),
      .rec_o      (rec[g]),
      .lt_o       (lt[g]),
      .eq_o       (eq[g]),
      .rd_o       (rd[g])
    );
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q[EntryW-1:0];
  assign out_key_o     = out_q.key;
  assign out_amount_o  = out_q.amount;
  assign out_price_o   = out_q.price;

endmodule
